### rtl/core/shuffled_lcg_random_generator_macros.svh
// Assertion macros used by the generator's top-level RTL file.
`ifndef SHUFFLED_LCG_RANDOM_GENERATOR_MACROS_SVH
`define SHUFFLED_LCG_RANDOM_GENERATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SLRG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SLRG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/slrg_pkg.sv
// Constants, codes and the LCG step function of the shuffled generator.
package slrg_pkg;

    localparam int VAL_W = 31;

    localparam int SLRG_TABLE_SIZE   = 97;
    localparam int SLRG_WARMUP_DRAWS = 197;

    localparam logic [VAL_W-1:0] LCG_MUL = 31'd1103515245;
    localparam logic [VAL_W-1:0] LCG_ADD = 31'd12345;

    localparam logic KIND_SEED = 1'b0;
    localparam logic KIND_DRAW = 1'b1;

    // x' = (LCG_MUL * x + LCG_ADD) mod 2^31
    function automatic logic [VAL_W-1:0] lcg_next(input logic [VAL_W-1:0] x);
        logic [VAL_W-1:0] sum;
        sum = VAL_W'(LCG_MUL * x + LCG_ADD);
        return sum;
    endfunction

endpackage

### rtl/core/slrg_if.sv
// Valid/ready channel interfaces for the generator's request and result streams.
interface slrg_in_if import slrg_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             kind;
    logic [VAL_W-1:0] seed;

    modport source (output valid, kind, seed, input ready);
    modport sink   (input valid, kind, seed, output ready);
endinterface

interface slrg_out_if import slrg_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] value;

    modport source (output valid, value, input ready);
    modport sink   (input valid, value, output ready);
endinterface

### rtl/core/slrg_table.sv
// Shuffle table: single-port-write, single-port-read RAM with registered read data.
module slrg_table import slrg_pkg::*; #(
    parameter int DEPTH  = SLRG_TABLE_SIZE,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [VAL_W-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [VAL_W-1:0]  o_rdata
);

    logic [VAL_W-1:0] mem [DEPTH];
    logic [VAL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/shuffled_lcg_random_generator.sv
// Top level: 31-bit LCG feeding a shuffle table, one random fraction per draw transaction.
//
// Usage:
//   i_in carries requests: kind = KIND_SEED loads the LCG from seed and
//   produces no result; kind = KIND_DRAW produces one 0.31 fraction on o_out.
//   A seed transaction is done on acceptance. A draw has a read step and a
//   write-back step: the index is computed from the last pick and the table
//   entry is read, then the entry is written back with a fresh LCG draw while
//   the value goes to the output register. The registered read data of the
//   table RAM sets this. The first draw after reset also runs the fill
//   sequence in place: discarded warm-up draws, one table write per cycle,
//   pick load, first read. The write-back state loads the result into
//   the output register that drives o_out.valid.
//   The output register decouples the sides: a request is accepted while a
//   result waits; a stalled receiver holds a draw in its write-back cycle
//   until the output register frees up. Reads and writes of the table never
//   overlap, so no forwarding is needed.
//   Reset clears the LCG state to zero and marks the table unfilled; the
//   table RAM itself is not cleared.
module shuffled_lcg_random_generator import slrg_pkg::*; #(
    parameter int TABLE_SIZE   = SLRG_TABLE_SIZE,
    parameter int WARMUP_DRAWS = SLRG_WARMUP_DRAWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slrg_in_if.sink     i_in,
    slrg_out_if.source  o_out
);

    `include "shuffled_lcg_random_generator_macros.svh"

    localparam int ADDR_W   = $clog2(TABLE_SIZE);
    localparam int TS_W     = $clog2(TABLE_SIZE + 1);
    localparam int PROD_W   = VAL_W + TS_W;
    localparam int FILL_LEN = WARMUP_DRAWS + TABLE_SIZE;
    localparam int CNT_W    = $clog2(FILL_LEN);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_FILL = 5'b00010,
        S_PICK = 5'b00100,
        S_LOOK = 5'b01000,
        S_READ = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic               r_init;
    logic [VAL_W-1:0]   r_lcg;
    logic [VAL_W-1:0]   r_pick;
    logic [CNT_W-1:0]   r_cnt;
    logic [ADDR_W-1:0]  r_idx;
    logic               r_out_valid;
    logic [VAL_W-1:0]   r_out_value;

    logic               in_acc, seed_load, draw_go, out_free, lcg_adv;
    logic [VAL_W-1:0]   lcg_src, lcg_nx;
    logic [PROD_W-1:0]  pick_prod;
    logic [TS_W-1:0]    pick_hi;
    logic [ADDR_W-1:0]  idx;
    logic [CNT_W-1:0]   cnt_off;
    logic               fill_we;
    logic               tbl_we, tbl_re;
    logic [ADDR_W-1:0]  tbl_waddr;
    logic [VAL_W-1:0]   tbl_rdata;

    assign i_in.ready  = (r_state == S_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign seed_load   = in_acc && (i_in.kind == KIND_SEED);
    assign draw_go     = in_acc && (i_in.kind == KIND_DRAW);
    assign out_free    = !r_out_valid || o_out.ready;

    assign o_out.valid = r_out_valid;
    assign o_out.value = r_out_value;

    // at most one LCG step per cycle, shared by seed load, fill and draw write-back
    assign lcg_adv = (r_state == S_FILL) || (r_state == S_PICK)
                     || ((r_state == S_READ) && out_free);
    assign lcg_src = seed_load ? i_in.seed : r_lcg;
    assign lcg_nx  = lcg_next(lcg_src);

    // index = floor(TABLE_SIZE * pick / 2^31), clamped to the last entry
    assign pick_prod = PROD_W'(TABLE_SIZE) * PROD_W'(r_pick);
    assign pick_hi   = pick_prod[VAL_W +: TS_W];
    assign idx       = (pick_hi > TS_W'(TABLE_SIZE - 1)) ? ADDR_W'(TABLE_SIZE - 1)
                                                         : pick_hi[ADDR_W-1:0];

    assign cnt_off   = r_cnt - CNT_W'(WARMUP_DRAWS);
    assign fill_we   = (r_state == S_FILL) && (r_cnt >= CNT_W'(WARMUP_DRAWS));

    assign tbl_re    = (draw_go && r_init) || (r_state == S_LOOK);
    assign tbl_we    = fill_we || ((r_state == S_READ) && out_free);
    assign tbl_waddr = (r_state == S_FILL) ? cnt_off[ADDR_W-1:0] : r_idx;

    slrg_table #(
        .DEPTH  (TABLE_SIZE),
        .ADDR_W (ADDR_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (r_lcg),
        .i_re    (tbl_re),
        .i_raddr (idx),
        .o_rdata (tbl_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (draw_go) begin
                    n_state = r_init ? S_READ : S_FILL;
                end
            end
            S_FILL: begin
                if (r_cnt == CNT_W'(FILL_LEN - 1)) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: n_state = S_LOOK;
            S_LOOK: n_state = S_READ;
            S_READ: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_init      <= 1'b0;
            r_lcg       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (seed_load || lcg_adv) begin
                r_lcg <= lcg_nx;
            end
            if (r_state == S_PICK) begin
                r_init <= 1'b1;
            end
            if ((r_state == S_READ) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_cnt <= '0;
        end else if (r_state == S_FILL) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (tbl_re) begin
            r_idx <= idx;
        end
        if (r_state == S_PICK) begin
            r_pick <= r_lcg;
        end else if ((r_state == S_READ) && out_free) begin
            r_pick      <= tbl_rdata;
            r_out_value <= tbl_rdata;
        end
    end

    `SLRG_ASSERT_NOW(a_no_rw_overlap, i_clk, i_rst_n, tbl_re, !tbl_we,
        "table read and write in the same cycle")
    `SLRG_ASSERT_NOW(a_waddr_range, i_clk, i_rst_n, tbl_we,
        tbl_waddr <= ADDR_W'(TABLE_SIZE - 1), "table write address out of range")
    `SLRG_ASSERT_NOW(a_raddr_range, i_clk, i_rst_n, tbl_re,
        idx <= ADDR_W'(TABLE_SIZE - 1), "table read address out of range")
    `SLRG_ASSERT_NEXT(a_draw_reads, i_clk, i_rst_n, draw_go && r_init,
        r_state == S_READ, "initialized draw did not go to write-back")
    `SLRG_ASSERT_NOW(a_out_from_read, i_clk, i_rst_n, $rose(r_out_valid),
        $past(r_state) == S_READ, "result appeared outside write-back")

endmodule

### tb/slrg_draw_checker.sv
// Checker: predicts each random fraction of the shuffled generator and compares the results.
`timescale 1ns / 1ps
module slrg_draw_checker import slrg_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    slrg_in_if   i_req,
    slrg_out_if  i_res,
    output int   o_errors,
    output int   o_waiting,
    output int   o_compared
);
    localparam int          TS    = SLRG_TABLE_SIZE;
    localparam logic [63:0] MULT  = 64'd1103515245;
    localparam logic [63:0] INCR  = 64'd12345;
    localparam int          SHOWN = 40;

    logic [VAL_W-1:0] lcg_x;
    logic [VAL_W-1:0] mix_tbl [TS];
    logic [VAL_W-1:0] pick;
    logic             filled;
    logic [VAL_W-1:0] fraction_q [$];
    logic [VAL_W-1:0] want;

    function automatic logic [VAL_W-1:0] lcg_step(input logic [VAL_W-1:0] x);
        logic [63:0] p;
        p = MULT * {33'd0, x} + INCR;
        return p[VAL_W-1:0];
    endfunction

    // Return the current state, then advance it.
    function automatic logic [VAL_W-1:0] take_raw();
        logic [VAL_W-1:0] r;
        r = lcg_x;
        lcg_x = lcg_step(lcg_x);
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] next_fraction();
        logic [63:0]      slot;
        logic [VAL_W-1:0] v;
        int               i;
        // First draw after reset: discard the warm-up draws, fill the table, load the pick.
        if (!filled) begin
            filled = 1'b1;
            for (i = 0; i < SLRG_WARMUP_DRAWS; i++)
                void'(take_raw());
            for (i = 0; i < TS; i++)
                mix_tbl[i] = take_raw();
            pick = take_raw();
        end
        slot = (64'(TS) * {33'd0, pick}) >> VAL_W;
        if (slot >= 64'(TS))
            slot = 64'(TS - 1);
        v = mix_tbl[int'(slot)];
        pick = v;
        mix_tbl[int'(slot)] = take_raw();
        return v;
    endfunction

    task automatic report(input string msg);
        if (o_errors < SHOWN)
            $display("%0t ns: mismatch: %s", $time, msg);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lcg_x = '0;
            pick = '0;
            filled = 1'b0;
            fraction_q.delete();
            o_errors = 0;
            o_waiting = 0;
            o_compared = 0;
        end else begin
            // Check the result first: it always belongs to an earlier transaction.
            if (i_res.valid && i_res.ready) begin
                if (fraction_q.size() == 0) begin
                    report($sformatf("value %h arrived with nothing expected", i_res.value));
                end else begin
                    want = fraction_q.pop_front();
                    o_compared++;
                    if (i_res.value !== want)
                        report($sformatf("value %h, expected %h", i_res.value, want));
                end
            end
            if (i_req.valid && i_req.ready) begin
                if (i_req.kind == KIND_SEED)
                    lcg_x = lcg_step(i_req.seed);
                else
                    fraction_q.push_back(next_fraction());
            end
            o_waiting = fraction_q.size();
        end
    end
endmodule

### tb/shuffled_lcg_random_generator_test.sv
// Testbench top: drives seed and draw transactions into the generator and gives the verdict.
`timescale 1ns / 1ps
module shuffled_lcg_random_generator_test;
    import slrg_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AT      = 400;
    localparam int RANDOM_ITEMS = 1425;
    localparam int DRAIN_LIMIT  = 2000;

    logic i_clk;
    logic i_rst_n;
    int   sent;
    int   draws_sent;
    int   seeds_sent;
    int   errors;
    int   waiting;
    int   compared;

    slrg_in_if  req_if ();
    slrg_out_if res_if ();

    shuffled_lcg_random_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    slrg_draw_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .i_res      (res_if),
        .o_errors   (errors),
        .o_waiting  (waiting),
        .o_compared (compared)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // No idling on either side over this span of transactions.
    function automatic bit quiet_span();
        return sent >= 800 && sent < 1000;
    endfunction

    function automatic logic [VAL_W-1:0] rand_seed();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    task automatic send_item(input logic kind, input logic [VAL_W-1:0] seed);
        @(negedge i_clk);
        while (!quiet_span() && $urandom_range(99) < 10) begin
            req_if.valid = 1'b0;
            req_if.kind  = 1'($urandom);
            req_if.seed  = VAL_W'($urandom);
            @(negedge i_clk);
        end
        req_if.valid = 1'b1;
        req_if.kind  = kind;
        req_if.seed  = seed;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        sent++;
        if (kind == KIND_DRAW)
            draws_sent++;
        else
            seeds_sent++;
    endtask

    initial begin : result_ready
        int hold_left;
        bit held;
        hold_left = 0;
        held = 1'b0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            // Hold off once for a long stretch so the block backs up into its input.
            if (!held && sent >= HOLD_AT) begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready = 1'b0;
            end else begin
                res_if.ready = quiet_span() || $urandom_range(99) >= 10;
            end
        end
    end

    initial begin : stimulus
        int i;
        int drain;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.kind = KIND_SEED;
        req_if.seed = '0;
        sent = 0;
        draws_sent = 0;
        seeds_sent = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Draw without a seed: start from state zero and run the fill pass.
        send_item(KIND_DRAW, '1);
        send_item(KIND_DRAW, '0);
        send_item(KIND_DRAW, VAL_W'($urandom));
        // Seed loads after the fill keep the table contents.
        send_item(KIND_SEED, '0);
        send_item(KIND_DRAW, '0);
        send_item(KIND_DRAW, '1);
        send_item(KIND_SEED, '1);
        send_item(KIND_DRAW, '0);
        // Back-to-back seed loads: only the last one counts.
        send_item(KIND_SEED, 31'h5555_5555);
        send_item(KIND_SEED, 31'h2aaa_aaaa);
        send_item(KIND_DRAW, 31'h5555_5555);
        send_item(KIND_DRAW, 31'h2aaa_aaaa);
        send_item(KIND_DRAW, '0);
        send_item(KIND_SEED, 31'd1);
        send_item(KIND_DRAW, '1);
        send_item(KIND_SEED, 31'h4000_0000);
        send_item(KIND_DRAW, '0);
        send_item(KIND_DRAW, '0);
        send_item(KIND_SEED, '1);
        send_item(KIND_SEED, '1);
        send_item(KIND_DRAW, '0);
        send_item(KIND_DRAW, '0);
        send_item(KIND_DRAW, '0);
        send_item(KIND_SEED, 31'h0000_3039);
        send_item(KIND_DRAW, '1);

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if ($urandom_range(99) < 20)
                send_item(KIND_SEED, rand_seed());
            else
                send_item(KIND_DRAW, VAL_W'($urandom));
        end
        @(negedge i_clk);
        req_if.valid = 1'b0;

        drain = 0;
        while (waiting != 0 && drain < DRAIN_LIMIT) begin
            @(negedge i_clk);
            drain++;
        end
        repeat (20) @(negedge i_clk);

        $display("covered %0d draw and %0d seed transactions, %0d fractions compared",
                 draws_sent, seeds_sent, compared);
        $display("included unseeded start with fill pass, seed extremes, %0d-cycle output hold",
                 HOLD_CYCLES);
        if (waiting != 0)
            $display("%0d expected fractions never arrived", waiting);
        if (errors == 0 && waiting == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout: run did not complete");
        $display("status: fail");
        $finish;
    end
endmodule
